>>> sv/arps_pkg.sv
// Shared types and constants of the autoregressive process generator.
package arps_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W    = 32;  // Q16.16 samples
    localparam int COEF_W    = 24;  // Q4.20 coefficients
    localparam int ORD_W     = 3;   // order register
    localparam int REG_IDX_W = 3;   // configuration index
    localparam int ACC_SHIFT = 20;  // Q.36 sum back to Q.16

    // Defaults for the top-level parameters.
    localparam int MAX_ORDER_DEF  = 5;
    localparam int FIFO_DEPTH_DEF = 8;

    // Saturation limits of a sample.
    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Configuration register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_ORDER         = 3'd0,
        REG_MEAN_SHIFT    = 3'd1,
        REG_INITIAL_VALUE = 3'd2,
        REG_COEF_0        = 3'd3,
        REG_COEF_1        = 3'd4,
        REG_COEF_2        = 3'd5,
        REG_COEF_3        = 3'd6,
        REG_COEF_4        = 3'd7
    } t_reg_idx;

    // Control that every cell of the filter chain sees.
    typedef struct packed {
        logic en;     // a sample is computed this cycle
        logic fresh;  // history holds the reload value
    } t_cell_ctrl;

    // One result word as it waits in the output queue.
    typedef struct packed {
        logic                     last;
        logic                     saturated;
        logic signed [DATA_W-1:0] sample;
    } t_out_word;

endpackage

>>> sv/arps_cell.sv
// One tap of the transposed all-pole filter chain.
module arps_cell import arps_pkg::*; #(
    parameter int WIDE_W = 60,
    parameter int SUM_W  = 27
) (
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [COEF_W-1:0] i_coef,        // coefficient, zero when tap unused
    input  logic signed [DATA_W-1:0] i_acc,         // new centered sample
    input  logic signed [DATA_W-1:0] i_reload,      // history reload value
    input  logic signed [SUM_W-1:0]  i_sum_next,    // coefficient sum of the taps beyond
    output logic signed [SUM_W-1:0]  o_sum,
    input  logic signed [WIDE_W-1:0] i_state_next,  // partial sum of the next cell
    output logic signed [WIDE_W-1:0] o_state
);

    logic signed [WIDE_W-1:0]       r_state;
    logic signed [WIDE_W-1:0]       n_state;
    logic signed [SUM_W-1:0]        r_sum;
    logic signed [WIDE_W-1:0]       r_reload_state;
    logic signed [DATA_W+COEF_W-1:0] w_prod;
    logic signed [DATA_W+SUM_W-1:0] w_reload_prod;

    // Suffix sum of coefficients, used to rebuild the partial sum on reload.
    assign o_sum = SUM_W'(i_coef) + i_sum_next;

    // Partial sum when every history entry equals the reload value.
    assign w_reload_prod = i_reload * r_sum;

    // Tap product of the new sample, added to the neighbor's partial sum.
    assign w_prod  = i_coef * i_acc;
    assign n_state = WIDE_W'(w_prod) + i_state_next;

    always_ff @(posedge i_clk) begin
        r_sum          <= o_sum;
        r_reload_state <= WIDE_W'(w_reload_prod);
        if (i_ctrl.en) begin
            r_state <= n_state;
        end
    end

    // After a reload the stored partial sum is replaced by the reload sum.
    assign o_state = i_ctrl.fresh ? r_reload_state : r_state;

endmodule

>>> sv/arps_out_fifo.sv
// Output queue that holds finished result words until they are taken.
module arps_out_fifo import arps_pkg::*; #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_rd;

    assign o_rd_valid = (r_count != '0);
    assign w_rd       = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_wr_en, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/ar_process_synthesis.sv
// Autoregressive process generator of order 1 to MAX_ORDER, one sample per word.
//
// Each innovation word yields one output word: the new process value
// y = sat(sat(innovation + sum coef_k * history_k) + mean_shift), Q16.16, with
// tuser raised when either saturation hit. The block takes one word per cycle
// while fewer than FIFO_DEPTH words are in flight or queued. A result passes
// the input, alignment and output registers and the queue before it is valid
// on the master side. The rate is set by the feedback loop through the first
// cell of the tap chain, which in the same cycle rounds and saturates the sum,
// multiplies the new sample by every coefficient and adds the products into
// the partial sums that the cells pass down the chain. Results queue in an
// eight-word buffer, so input keeps flowing while a result waits. The history
// reloads to sat(initial_value - mean_shift) after reset, after any register
// write and after a word with tlast set, without a lost cycle; the first word
// may be accepted in the cycle after a register write. Register writes are
// meant to be done while no words are in flight.
module ar_process_synthesis import arps_pkg::*; #(
    parameter int MAX_ORDER  = MAX_ORDER_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    // Innovation stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] innovation
    input  logic                 s_axis_tuser,   // [0] innovation_missing
    input  logic                 s_axis_tlast,   // last_in
    // Process output stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,   // [31:0] sample_out
    output logic                 m_axis_tuser,   // [0] saturated
    output logic                 m_axis_tlast    // last_out
);

    localparam int SUM_W  = COEF_W + $clog2(MAX_ORDER) + 1;
    localparam int WIDE_W = DATA_W + COEF_W + $clog2(MAX_ORDER + 1) + 1;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam logic [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) << (ACC_SHIFT - 1);

    // Configuration registers.
    logic [ORD_W-1:0]         r_order;
    logic signed [DATA_W-1:0] r_mean;
    logic signed [DATA_W-1:0] r_init;
    logic signed [COEF_W-1:0] r_coef [MAX_ORDER];

    logic w_cfg_wr;
    logic w_in_acc;
    logic w_out_acc;

    // Pipeline registers.
    logic                     r_v1, r_v2, r_v3;
    logic signed [DATA_W-1:0] r_x1;
    logic                     r_last1, r_last2, r_last3;
    logic signed [WIDE_W-1:0] r_xr2;
    logic signed [DATA_W-1:0] r_acc3;
    logic                     r_flag3;
    logic                     r_fresh;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [DATA_W-1:0] r_reload;

    logic [ORD_W-1:0]         w_taps;
    logic signed [COEF_W-1:0] w_coef_eff [MAX_ORDER];
    logic signed [SUM_W-1:0]  w_sum   [MAX_ORDER+1];
    logic signed [WIDE_W-1:0] w_state [MAX_ORDER+1];
    t_cell_ctrl               w_ctrl;

    logic signed [WIDE_W-1:0] w_wide;
    logic                     w_acc_ovf;
    logic signed [DATA_W-1:0] w_acc;
    logic signed [DATA_W:0]   w_y_wide;
    logic                     w_y_ovf;
    logic signed [DATA_W:0]   w_c_wide;
    logic signed [DATA_W-1:0] w_c;
    t_out_word                w_wr_word;
    t_out_word                w_rd_word;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_out_acc   = m_axis_tvalid && m_axis_tready;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORD_W'(1);
            r_mean  <= '0;
            r_init  <= '0;
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_coef[k] <= '0;
            end
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ORDER:         r_order <= i_cfg_data[ORD_W-1:0];
                REG_MEAN_SHIFT:    r_mean  <= i_cfg_data;
                REG_INITIAL_VALUE: r_init  <= i_cfg_data;
                default: begin
                    for (int k = 0; k < MAX_ORDER; k++) begin
                        if (i_cfg_index == REG_IDX_W'(REG_COEF_0) + REG_IDX_W'(k)) begin
                            r_coef[k] <= i_cfg_data[COEF_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    // Taps in use: order zero acts as one, larger orders clamp to the chain length.
    always_comb begin
        if (r_order == '0) begin
            w_taps = ORD_W'(1);
        end else if (r_order > ORD_W'(MAX_ORDER)) begin
            w_taps = ORD_W'(MAX_ORDER);
        end else begin
            w_taps = r_order;
        end
    end

    // Reload value sat(initial_value - mean_shift), registered for the cells.
    assign w_c_wide = {r_init[DATA_W-1], r_init} - {r_mean[DATA_W-1], r_mean};
    assign w_c = (w_c_wide[DATA_W] != w_c_wide[DATA_W-1])
               ? (w_c_wide[DATA_W] ? DATA_MIN : DATA_MAX)
               : w_c_wide[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        r_reload <= w_c;
    end

    // Input stages: mask a missing innovation, then align it to Q.36 with the
    // rounding half already in the low bits, which are zero after the shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_in_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1    <= s_axis_tuser ? '0 : s_axis_tdata;
        r_last1 <= s_axis_tlast;
        r_xr2   <= (WIDE_W'(r_x1) <<< ACC_SHIFT) | ROUND_HALF;
        r_last2 <= r_last1;
    end

    // Chain of filter cells; the last cell sees zero beyond the chain.
    assign w_state[MAX_ORDER] = '0;
    assign w_sum[MAX_ORDER]   = '0;
    assign w_ctrl.en          = r_v2;
    assign w_ctrl.fresh       = r_fresh;

    for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
        assign w_coef_eff[k] = (ORD_W'(k) < w_taps) ? r_coef[k] : '0;

        arps_cell #(
            .WIDE_W (WIDE_W),
            .SUM_W  (SUM_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_coef       (w_coef_eff[k]),
            .i_acc        (w_acc),
            .i_reload     (r_reload),
            .i_sum_next   (w_sum[k+1]),
            .o_sum        (w_sum[k]),
            .i_state_next (w_state[k+1]),
            .o_state      (w_state[k])
        );
    end

    // New centered sample: round the full sum to Q16.16 and saturate.
    assign w_wide    = r_xr2 + w_state[0];
    assign w_acc_ovf = !((&w_wide[WIDE_W-1:ACC_SHIFT+DATA_W-1])
                      || !(|w_wide[WIDE_W-1:ACC_SHIFT+DATA_W-1]));
    assign w_acc     = w_acc_ovf ? (w_wide[WIDE_W-1] ? DATA_MIN : DATA_MAX)
                                 : w_wide[ACC_SHIFT+DATA_W-1:ACC_SHIFT];

    always_ff @(posedge i_clk) begin
        r_acc3  <= w_acc;
        r_flag3 <= w_acc_ovf;
        r_last3 <= r_last2;
    end

    // History state: reloaded on reset, on a register write and after a last word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= 1'b1;
        end else if (w_cfg_wr) begin
            r_fresh <= 1'b1;
        end else if (r_v2) begin
            r_fresh <= r_last2;
        end
    end

    // Mean added to the output, saturated.
    assign w_y_wide = {r_acc3[DATA_W-1], r_acc3} + {r_mean[DATA_W-1], r_mean};
    assign w_y_ovf  = (w_y_wide[DATA_W] != w_y_wide[DATA_W-1]);

    assign w_wr_word.sample    = w_y_ovf ? (w_y_wide[DATA_W] ? DATA_MIN : DATA_MAX)
                                         : w_y_wide[DATA_W-1:0];
    assign w_wr_word.saturated = r_flag3 || w_y_ovf;
    assign w_wr_word.last      = r_last3;

    arps_out_fifo #(
        .WIDTH ($bits(t_out_word)),
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (r_v3),
        .i_wr_data  (w_wr_word),
        .o_rd_valid (m_axis_tvalid),
        .i_rd_ready (m_axis_tready),
        .o_rd_data  (w_rd_word)
    );

    assign m_axis_tdata = w_rd_word.sample;
    assign m_axis_tuser = w_rd_word.saturated;
    assign m_axis_tlast = w_rd_word.last;

    // Words in flight plus words queued; the queue can never overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({w_in_acc, w_out_acc})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign s_axis_tready = (r_cnt < CNT_W'(FIFO_DEPTH));

    // Checks on the word accounting and the reload control.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FIFO_DEPTH))
        else $error("word count exceeds queue depth");

    a_out_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid || r_v1 || r_v2 || r_v3) |-> (r_cnt != '0))
        else $error("word present but count is zero");

    a_cfg_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> r_fresh)
        else $error("history not reloaded after register write");

    a_last_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_last2 && !w_cfg_wr) |=> r_fresh)
        else $error("history not reloaded after last word");

endmodule
